// ===== design/srs_pkg.sv =====
// ----------------------------------------------------------------------------
// srs_pkg
// Shared types and constants of the sensor record statistics block.
// ----------------------------------------------------------------------------
package srs_pkg;

  localparam int SF_SLOTS  = 22;
  localparam int TIME_BITS = 40;

  localparam int STAMP_W = 40;
  localparam int MASK_W  = 5;
  localparam int TEMP_W  = 16;
  localparam int HUM_W   = 14;
  localparam int PRES_W  = 17;
  localparam int BATT_W  = 16;
  localparam int SF_W    = 5;
  localparam int IDX_W   = 5;
  localparam int VALUE_W = 64;

  localparam int CNT_W  = 32;
  localparam int MEAS_W = 18;
  localparam int SUM_W  = 50;
  localparam int N_MEAS = 3;

  // Measurement slots.
  localparam int M_TEMP = 0;
  localparam int M_HUM  = 1;
  localparam int M_PRES = 2;

  // Bits of the presence mask.
  localparam int MASK_TEMP = 0;
  localparam int MASK_HUM  = 1;
  localparam int MASK_PRES = 2;
  localparam int MASK_BATT = 3;
  localparam int MASK_SF   = 4;

  // Bits of the battery flags.
  localparam int BF_FIRST = 0;
  localparam int BF_LAST  = 1;

  typedef logic signed [MEAS_W-1:0] meas_t;
  typedef logic signed [SUM_W-1:0]  sum_t;
  typedef logic [TIME_BITS-1:0]     time_t;

  localparam meas_t MEAS_HI = {1'b0, {(MEAS_W-1){1'b1}}};
  localparam meas_t MEAS_LO = {1'b1, {(MEAS_W-1){1'b0}}};
  localparam sum_t  SUM_HI  = {1'b0, {(SUM_W-1){1'b1}}};
  localparam sum_t  SUM_LO  = {1'b1, {(SUM_W-1){1'b0}}};

  typedef enum logic {
    OP_ACC  = 1'b0,
    OP_READ = 1'b1
  } op_t;

  typedef enum logic [IDX_W-1:0] {
    STAT_COUNT          = 5'd0,
    STAT_TEMP_MIN       = 5'd1,
    STAT_TEMP_MAX       = 5'd2,
    STAT_TEMP_MIN_TIME  = 5'd3,
    STAT_TEMP_MAX_TIME  = 5'd4,
    STAT_TEMP_SUM       = 5'd5,
    STAT_HUM_MIN        = 5'd6,
    STAT_HUM_MAX        = 5'd7,
    STAT_HUM_MIN_TIME   = 5'd8,
    STAT_HUM_MAX_TIME   = 5'd9,
    STAT_HUM_SUM        = 5'd10,
    STAT_PRES_MIN       = 5'd11,
    STAT_PRES_MAX       = 5'd12,
    STAT_PRES_MIN_TIME  = 5'd13,
    STAT_PRES_MAX_TIME  = 5'd14,
    STAT_PRES_SUM       = 5'd15,
    STAT_BATT_FIRST     = 5'd16,
    STAT_BATT_FIRST_T   = 5'd17,
    STAT_BATT_LAST      = 5'd18,
    STAT_BATT_LAST_T    = 5'd19,
    STAT_BATT_FLAGS     = 5'd20,
    STAT_SF_SEEN        = 5'd21,
    STAT_PERIOD_START   = 5'd22,
    STAT_PERIOD_END     = 5'd23,
    STAT_PERIOD_VALID   = 5'd24
  } stat_idx_t;

  typedef struct packed {
    op_t                     op;
    logic [STAMP_W-1:0]      stamp;
    logic [MASK_W-1:0]       present_mask;
    logic signed [TEMP_W-1:0] temperature;
    logic [HUM_W-1:0]        humidity;
    logic [PRES_W-1:0]       pressure;
    logic [BATT_W-1:0]       battery;
    logic [SF_W-1:0]         spread_factor;
    logic [IDX_W-1:0]        stat_index;
  } item_t;

  typedef struct {
    logic [CNT_W-1:0]  record_count;
    meas_t             meas_min      [N_MEAS];
    meas_t             meas_max      [N_MEAS];
    time_t             meas_min_time [N_MEAS];
    time_t             meas_max_time [N_MEAS];
    sum_t              meas_sum      [N_MEAS];
    logic [BATT_W-1:0] batt_first;
    time_t             batt_first_time;
    logic [BATT_W-1:0] batt_last;
    time_t             batt_last_time;
    logic [1:0]        batt_flags;
    logic [SF_SLOTS-1:0] sf_seen;
    time_t             period_start;
    time_t             period_end;
    logic              period_valid;
  } stats_t;

endpackage

// ===== design/srs_stats.sv =====
// ----------------------------------------------------------------------------
// srs_stats
// Statistics registers and their update from one record.
// ----------------------------------------------------------------------------
module srs_stats (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           upd_en,
  input  srs_pkg::item_t rec,
  output srs_pkg::stats_t stats
);
  import srs_pkg::*;

  stats_t st_r;
  stats_t st_nxt;

  logic [STAMP_W+TIME_BITS-1:0] stamp_ext;
  time_t                        t;
  meas_t                        meas_in  [N_MEAS];
  logic [N_MEAS-1:0]            meas_on;
  logic signed [SUM_W:0]        sum_ext  [N_MEAS];
  sum_t                         sum_sat  [N_MEAS];
  logic                         sf_ok;

  // Only the low TIME_BITS bits of the stamp take part.
  assign stamp_ext = {{TIME_BITS{1'b0}}, rec.stamp};
  assign t         = stamp_ext[TIME_BITS-1:0];

  assign meas_in[M_TEMP] = MEAS_W'(rec.temperature);
  assign meas_in[M_HUM]  = MEAS_W'(rec.humidity);
  assign meas_in[M_PRES] = MEAS_W'(rec.pressure);

  assign meas_on[M_TEMP] = rec.present_mask[MASK_TEMP];
  assign meas_on[M_HUM]  = rec.present_mask[MASK_HUM];
  assign meas_on[M_PRES] = rec.present_mask[MASK_PRES];

  assign sf_ok = rec.present_mask[MASK_SF] &&
                 ({1'b0, rec.spread_factor} < (SF_W+1)'(SF_SLOTS));

  // Sums carry one guard bit; a differing top pair means the range was left.
  always_comb begin
    for (int k = 0; k < N_MEAS; k++) begin
      sum_ext[k] = (SUM_W+1)'(st_r.meas_sum[k]) + (SUM_W+1)'(meas_in[k]);
      if (sum_ext[k][SUM_W] != sum_ext[k][SUM_W-1]) begin
        sum_sat[k] = sum_ext[k][SUM_W] ? SUM_LO : SUM_HI;
      end else begin
        sum_sat[k] = sum_ext[k][SUM_W-1:0];
      end
    end
  end

  always_comb begin
    st_nxt = st_r;
    for (int k = 0; k < N_MEAS; k++) begin
      if (meas_on[k]) begin
        if (meas_in[k] < st_r.meas_min[k]) begin
          st_nxt.meas_min[k]      = meas_in[k];
          st_nxt.meas_min_time[k] = t;
        end
        if (meas_in[k] > st_r.meas_max[k]) begin
          st_nxt.meas_max[k]      = meas_in[k];
          st_nxt.meas_max_time[k] = t;
        end
        st_nxt.meas_sum[k] = sum_sat[k];
      end
    end

    if (rec.present_mask[MASK_BATT]) begin
      if (!st_r.batt_flags[BF_FIRST] || (t < st_r.batt_first_time)) begin
        st_nxt.batt_first           = rec.battery;
        st_nxt.batt_first_time      = t;
        st_nxt.batt_flags[BF_FIRST] = 1'b1;
      end
      if (!st_r.batt_flags[BF_LAST] || (t > st_r.batt_last_time)) begin
        st_nxt.batt_last           = rec.battery;
        st_nxt.batt_last_time      = t;
        st_nxt.batt_flags[BF_LAST] = 1'b1;
      end
    end

    if (sf_ok) begin
      st_nxt.sf_seen = st_r.sf_seen | (SF_SLOTS'(1) << rec.spread_factor);
    end

    if (!st_r.period_valid || (t < st_r.period_start)) begin
      st_nxt.period_start = t;
    end
    if (!st_r.period_valid || (t > st_r.period_end)) begin
      st_nxt.period_end = t;
    end
    st_nxt.period_valid = 1'b1;

    if (st_r.record_count != {CNT_W{1'b1}}) begin
      st_nxt.record_count = st_r.record_count + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r.record_count <= '0;
      for (int k = 0; k < N_MEAS; k++) begin
        st_r.meas_min[k]      <= MEAS_HI;
        st_r.meas_max[k]      <= MEAS_LO;
        st_r.meas_min_time[k] <= '0;
        st_r.meas_max_time[k] <= '0;
        st_r.meas_sum[k]      <= '0;
      end
      st_r.batt_first      <= '0;
      st_r.batt_first_time <= '0;
      st_r.batt_last       <= '0;
      st_r.batt_last_time  <= '0;
      st_r.batt_flags      <= '0;
      st_r.sf_seen         <= '0;
      st_r.period_start    <= '0;
      st_r.period_end      <= '0;
      st_r.period_valid    <= 1'b0;
    end else if (upd_en) begin
      st_r <= st_nxt;
    end
  end

  assign stats = st_r;

endmodule

// ===== design/srs_read_sel.sv =====
// ----------------------------------------------------------------------------
// srs_read_sel
// Selects one statistic by index and extends it to the result width.
// ----------------------------------------------------------------------------
module srs_read_sel (
  input  srs_pkg::stats_t            stats,
  input  logic [srs_pkg::IDX_W-1:0]  stat_index,
  output logic signed [srs_pkg::VALUE_W-1:0] value
);
  import srs_pkg::*;

  // Measurement minimum, maximum and sum are signed; everything else is
  // zero extended.
  always_comb begin
    case (stat_idx_t'(stat_index))
      STAT_COUNT:         value = VALUE_W'(stats.record_count);
      STAT_TEMP_MIN:      value = VALUE_W'(stats.meas_min[M_TEMP]);
      STAT_TEMP_MAX:      value = VALUE_W'(stats.meas_max[M_TEMP]);
      STAT_TEMP_MIN_TIME: value = VALUE_W'(stats.meas_min_time[M_TEMP]);
      STAT_TEMP_MAX_TIME: value = VALUE_W'(stats.meas_max_time[M_TEMP]);
      STAT_TEMP_SUM:      value = VALUE_W'(stats.meas_sum[M_TEMP]);
      STAT_HUM_MIN:       value = VALUE_W'(stats.meas_min[M_HUM]);
      STAT_HUM_MAX:       value = VALUE_W'(stats.meas_max[M_HUM]);
      STAT_HUM_MIN_TIME:  value = VALUE_W'(stats.meas_min_time[M_HUM]);
      STAT_HUM_MAX_TIME:  value = VALUE_W'(stats.meas_max_time[M_HUM]);
      STAT_HUM_SUM:       value = VALUE_W'(stats.meas_sum[M_HUM]);
      STAT_PRES_MIN:      value = VALUE_W'(stats.meas_min[M_PRES]);
      STAT_PRES_MAX:      value = VALUE_W'(stats.meas_max[M_PRES]);
      STAT_PRES_MIN_TIME: value = VALUE_W'(stats.meas_min_time[M_PRES]);
      STAT_PRES_MAX_TIME: value = VALUE_W'(stats.meas_max_time[M_PRES]);
      STAT_PRES_SUM:      value = VALUE_W'(stats.meas_sum[M_PRES]);
      STAT_BATT_FIRST:    value = VALUE_W'(stats.batt_first);
      STAT_BATT_FIRST_T:  value = VALUE_W'(stats.batt_first_time);
      STAT_BATT_LAST:     value = VALUE_W'(stats.batt_last);
      STAT_BATT_LAST_T:   value = VALUE_W'(stats.batt_last_time);
      STAT_BATT_FLAGS:    value = VALUE_W'(stats.batt_flags);
      STAT_SF_SEEN:       value = VALUE_W'(stats.sf_seen);
      STAT_PERIOD_START:  value = VALUE_W'(stats.period_start);
      STAT_PERIOD_END:    value = VALUE_W'(stats.period_end);
      STAT_PERIOD_VALID:  value = VALUE_W'(stats.period_valid);
      default:            value = '0;
    endcase
  end

endmodule

// ===== design/sensor_record_statistics.sv =====
// ----------------------------------------------------------------------------
// sensor_record_statistics
// Running count, extremes, sums, battery and period tracking of sensor
// records, with read-back of one statistic per read transaction.
// ----------------------------------------------------------------------------
// The block accepts one transaction per clock while in_stall is low. Each
// transaction is captured in an input register; in the following cycle an
// accumulate transaction updates all statistics at once, while a read
// transaction selects one statistic into the result register as soon as
// that register is free, so a read result always reflects every record
// accepted before it. Accumulate transactions produce no result; a read
// waits in the input register only while a previous result is still held.
module sensor_record_statistics (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic                                in_op,
  input  logic [srs_pkg::STAMP_W-1:0]         in_stamp,
  input  logic [srs_pkg::MASK_W-1:0]          in_present_mask,
  input  logic signed [srs_pkg::TEMP_W-1:0]   in_temperature,
  input  logic [srs_pkg::HUM_W-1:0]           in_humidity,
  input  logic [srs_pkg::PRES_W-1:0]          in_pressure,
  input  logic [srs_pkg::BATT_W-1:0]          in_battery,
  input  logic [srs_pkg::SF_W-1:0]            in_spread_factor,
  input  logic [srs_pkg::IDX_W-1:0]           in_stat_index,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [srs_pkg::VALUE_W-1:0]  out_stat_value
);
  import srs_pkg::*;

  item_t                      item_r;
  logic                       item_valid_r;
  logic                       out_valid_r;
  logic signed [VALUE_W-1:0]  out_value_r;

  stats_t                     stats;
  logic signed [VALUE_W-1:0]  sel_value;
  logic                       in_take;
  logic                       out_free;
  logic                       item_go;
  logic                       upd_en;
  logic                       rd_en;

  assign out_free = !out_valid_r || !out_stall;
  assign item_go  = item_valid_r && ((item_r.op == OP_ACC) || out_free);
  assign upd_en   = item_go && (item_r.op == OP_ACC);
  assign rd_en    = item_go && (item_r.op == OP_READ);
  assign in_stall = item_valid_r && !item_go;
  assign in_take  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_valid_r <= 1'b0;
    end else if (in_take) begin
      item_valid_r <= 1'b1;
    end else if (item_go) begin
      item_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      item_r.op            <= op_t'(in_op);
      item_r.stamp         <= in_stamp;
      item_r.present_mask  <= in_present_mask;
      item_r.temperature   <= in_temperature;
      item_r.humidity      <= in_humidity;
      item_r.pressure      <= in_pressure;
      item_r.battery       <= in_battery;
      item_r.spread_factor <= in_spread_factor;
      item_r.stat_index    <= in_stat_index;
    end
  end

  srs_stats u_stats (
    .clk    (clk),
    .rst_n  (rst_n),
    .upd_en (upd_en),
    .rec    (item_r),
    .stats  (stats)
  );

  srs_read_sel u_read_sel (
    .stats      (stats),
    .stat_index (item_r.stat_index),
    .value      (sel_value)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (rd_en) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      out_value_r <= sel_value;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_stat_value = out_value_r;

endmodule

// ===== tb/sv/srs_stats_checker.sv =====
// ----------------------------------------------------------------------------
// srs_stats_checker
// Watches both channels of the sensor record statistics block, keeps its own
// copy of the running statistics and compares every read result against it.
// ----------------------------------------------------------------------------
module srs_stats_checker
  import srs_pkg::*;
(
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  input  logic                        in_stall,
  input  logic                        in_op,
  input  logic [STAMP_W-1:0]          in_stamp,
  input  logic [MASK_W-1:0]           in_present_mask,
  input  logic signed [TEMP_W-1:0]    in_temperature,
  input  logic [HUM_W-1:0]            in_humidity,
  input  logic [PRES_W-1:0]           in_pressure,
  input  logic [BATT_W-1:0]           in_battery,
  input  logic [SF_W-1:0]             in_spread_factor,
  input  logic [IDX_W-1:0]            in_stat_index,
  input  logic                        out_valid,
  input  logic                        out_stall,
  input  logic signed [VALUE_W-1:0]   out_stat_value,
  output int                          fail_count,
  output int                          pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic signed [VALUE_W-1:0] value;
    logic [IDX_W-1:0]          idx;
  } stat_read_t;

  stats_t     stats;
  stat_read_t reads_due[$];

  function automatic void clear_stats();
    stats.record_count = '0;
    for (int k = 0; k < N_MEAS; k++) begin
      stats.meas_min[k]      = MEAS_HI;
      stats.meas_max[k]      = MEAS_LO;
      stats.meas_min_time[k] = '0;
      stats.meas_max_time[k] = '0;
      stats.meas_sum[k]      = '0;
    end
    stats.batt_first      = '0;
    stats.batt_first_time = '0;
    stats.batt_last       = '0;
    stats.batt_last_time  = '0;
    stats.batt_flags      = '0;
    stats.sf_seen         = '0;
    stats.period_start    = '0;
    stats.period_end      = '0;
    stats.period_valid    = 1'b0;
  endfunction

  // Extremes move only on a strictly better value, so the first time is kept.
  function automatic void absorb_measure(int k, meas_t v, time_t t);
    longint total;
    if (v < stats.meas_min[k]) begin
      stats.meas_min[k]      = v;
      stats.meas_min_time[k] = t;
    end
    if (v > stats.meas_max[k]) begin
      stats.meas_max[k]      = v;
      stats.meas_max_time[k] = t;
    end
    total = longint'(stats.meas_sum[k]) + longint'(v);
    if (total > longint'(SUM_HI)) total = longint'(SUM_HI);
    if (total < longint'(SUM_LO)) total = longint'(SUM_LO);
    stats.meas_sum[k] = sum_t'(total);
  endfunction

  function automatic void absorb_record(time_t t, logic [MASK_W-1:0] mask,
                                        logic signed [TEMP_W-1:0] temp,
                                        logic [HUM_W-1:0] hum,
                                        logic [PRES_W-1:0] pres,
                                        logic [BATT_W-1:0] batt,
                                        logic [SF_W-1:0] sf);
    if (mask[MASK_TEMP]) absorb_measure(M_TEMP, meas_t'(temp), t);
    if (mask[MASK_HUM])  absorb_measure(M_HUM, meas_t'(hum), t);
    if (mask[MASK_PRES]) absorb_measure(M_PRES, meas_t'(pres), t);
    if (mask[MASK_BATT]) begin
      if (!stats.batt_flags[BF_FIRST] || t < stats.batt_first_time) begin
        stats.batt_first            = batt;
        stats.batt_first_time       = t;
        stats.batt_flags[BF_FIRST]  = 1'b1;
      end
      if (!stats.batt_flags[BF_LAST] || t > stats.batt_last_time) begin
        stats.batt_last             = batt;
        stats.batt_last_time        = t;
        stats.batt_flags[BF_LAST]   = 1'b1;
      end
    end
    if (mask[MASK_SF] && sf < SF_SLOTS) stats.sf_seen[sf] = 1'b1;
    if (!stats.period_valid || t < stats.period_start) stats.period_start = t;
    if (!stats.period_valid || t > stats.period_end) stats.period_end = t;
    stats.period_valid = 1'b1;
    if (stats.record_count != '1) stats.record_count++;
  endfunction

  function automatic logic signed [VALUE_W-1:0] stat_lookup(logic [IDX_W-1:0] idx);
    case (idx)
      STAT_COUNT:         return VALUE_W'(stats.record_count);
      STAT_TEMP_MIN:      return VALUE_W'(stats.meas_min[M_TEMP]);
      STAT_TEMP_MAX:      return VALUE_W'(stats.meas_max[M_TEMP]);
      STAT_TEMP_MIN_TIME: return VALUE_W'(stats.meas_min_time[M_TEMP]);
      STAT_TEMP_MAX_TIME: return VALUE_W'(stats.meas_max_time[M_TEMP]);
      STAT_TEMP_SUM:      return VALUE_W'(stats.meas_sum[M_TEMP]);
      STAT_HUM_MIN:       return VALUE_W'(stats.meas_min[M_HUM]);
      STAT_HUM_MAX:       return VALUE_W'(stats.meas_max[M_HUM]);
      STAT_HUM_MIN_TIME:  return VALUE_W'(stats.meas_min_time[M_HUM]);
      STAT_HUM_MAX_TIME:  return VALUE_W'(stats.meas_max_time[M_HUM]);
      STAT_HUM_SUM:       return VALUE_W'(stats.meas_sum[M_HUM]);
      STAT_PRES_MIN:      return VALUE_W'(stats.meas_min[M_PRES]);
      STAT_PRES_MAX:      return VALUE_W'(stats.meas_max[M_PRES]);
      STAT_PRES_MIN_TIME: return VALUE_W'(stats.meas_min_time[M_PRES]);
      STAT_PRES_MAX_TIME: return VALUE_W'(stats.meas_max_time[M_PRES]);
      STAT_PRES_SUM:      return VALUE_W'(stats.meas_sum[M_PRES]);
      STAT_BATT_FIRST:    return VALUE_W'(stats.batt_first);
      STAT_BATT_FIRST_T:  return VALUE_W'(stats.batt_first_time);
      STAT_BATT_LAST:     return VALUE_W'(stats.batt_last);
      STAT_BATT_LAST_T:   return VALUE_W'(stats.batt_last_time);
      STAT_BATT_FLAGS:    return VALUE_W'(stats.batt_flags);
      STAT_SF_SEEN:       return VALUE_W'(stats.sf_seen);
      STAT_PERIOD_START:  return VALUE_W'(stats.period_start);
      STAT_PERIOD_END:    return VALUE_W'(stats.period_end);
      STAT_PERIOD_VALID:  return VALUE_W'(stats.period_valid);
      default:            return '0;
    endcase
  endfunction

  function automatic void note_mismatch(string msg);
    fail_count++;
    if (fail_count <= 10) $display("%s", msg);
  endfunction

  initial begin
    fail_count = 0;
    pending    = 0;
  end

  // The result side is checked before the request side: a read accepted at
  // this edge cannot already be the transaction leaving the block.
  always @(posedge clk) begin : watch
    stat_read_t head;
    if (!rst_n) begin
      clear_stats();
      reads_due.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (reads_due.size() == 0) begin
          note_mismatch($sformatf("unexpected result %0d with no read outstanding",
                                  out_stat_value));
        end else begin
          head = reads_due.pop_front();
          if (out_stat_value !== head.value)
            note_mismatch($sformatf("stat %0d: expected %0d, got %0d",
                                    head.idx, head.value, out_stat_value));
        end
      end
      if (in_valid && !in_stall) begin
        if (in_op == OP_READ) begin
          head.value = stat_lookup(in_stat_index);
          head.idx   = in_stat_index;
          reads_due.push_back(head);
        end else begin
          absorb_record(in_stamp[TIME_BITS-1:0], in_present_mask, in_temperature,
                        in_humidity, in_pressure, in_battery, in_spread_factor);
        end
      end
    end
    pending = reads_due.size();
  end

endmodule

// ===== tb/sv/sensor_record_statistics_tb.sv =====
// ----------------------------------------------------------------------------
// sensor_record_statistics_tb
// Drives directed and random sensor records and statistic reads into the
// block with random gaps and result stalls; the checker gives the verdict.
// ----------------------------------------------------------------------------
module sensor_record_statistics_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import srs_pkg::*;

  localparam int              RANDOM_ITEMS  = 950;
  localparam logic [IDX_W-1:0] IDX_UNUSED_LO = 5'd25;
  localparam logic [IDX_W-1:0] IDX_UNUSED_HI = 5'd31;
  localparam logic [MASK_W-1:0] MASK_ALL    = '1;
  localparam logic [MASK_W-1:0] MASK_NONE   = '0;

  logic                      clk;
  logic                      rst_n;
  logic                      in_valid;
  logic                      in_stall;
  logic                      in_op;
  logic [STAMP_W-1:0]        in_stamp;
  logic [MASK_W-1:0]         in_present_mask;
  logic signed [TEMP_W-1:0]  in_temperature;
  logic [HUM_W-1:0]          in_humidity;
  logic [PRES_W-1:0]         in_pressure;
  logic [BATT_W-1:0]         in_battery;
  logic [SF_W-1:0]           in_spread_factor;
  logic [IDX_W-1:0]          in_stat_index;
  logic                      out_valid;
  logic                      out_stall;
  logic signed [VALUE_W-1:0] out_stat_value;

  int                 fail_count;
  int                 pending;
  bit                 sender_calm;
  bit                 receiver_calm;
  logic [STAMP_W-1:0] last_stamp;

  sensor_record_statistics u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_op            (in_op),
    .in_stamp         (in_stamp),
    .in_present_mask  (in_present_mask),
    .in_temperature   (in_temperature),
    .in_humidity      (in_humidity),
    .in_pressure      (in_pressure),
    .in_battery       (in_battery),
    .in_spread_factor (in_spread_factor),
    .in_stat_index    (in_stat_index),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_stat_value   (out_stat_value)
  );

  srs_stats_checker u_check (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_op            (in_op),
    .in_stamp         (in_stamp),
    .in_present_mask  (in_present_mask),
    .in_temperature   (in_temperature),
    .in_humidity      (in_humidity),
    .in_pressure      (in_pressure),
    .in_battery       (in_battery),
    .in_spread_factor (in_spread_factor),
    .in_stat_index    (in_stat_index),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_stat_value   (out_stat_value),
    .fail_count       (fail_count),
    .pending          (pending)
  );

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #2_000_000;
    $display("status: fail");
    $finish;
  end

  function automatic item_t make_record(logic [STAMP_W-1:0] stamp, logic [MASK_W-1:0] mask,
                                        logic signed [TEMP_W-1:0] temp,
                                        logic [HUM_W-1:0] hum, logic [PRES_W-1:0] pres,
                                        logic [BATT_W-1:0] batt, logic [SF_W-1:0] sf);
    item_t it;
    it               = '0;
    it.op            = OP_ACC;
    it.stamp         = stamp;
    it.present_mask  = mask;
    it.temperature   = temp;
    it.humidity      = hum;
    it.pressure      = pres;
    it.battery       = batt;
    it.spread_factor = sf;
    return it;
  endfunction

  // Reads carry random junk in the unused fields so that those bits toggle too.
  function automatic item_t make_read(logic [IDX_W-1:0] idx);
    item_t it;
    it            = item_t'({$urandom(), $urandom(), $urandom(), $urandom()});
    it.op         = OP_READ;
    it.stat_index = idx;
    return it;
  endfunction

  // Stamps often repeat or move by small steps so that ties and both
  // directions of the period and battery ordering come up regularly.
  function automatic item_t random_record();
    item_t it;
    it = item_t'({$urandom(), $urandom(), $urandom(), $urandom()});
    it.op = OP_ACC;
    case ($urandom_range(0, 3))
      0: ;
      1: last_stamp = last_stamp + STAMP_W'($urandom_range(1, 1000));
      2: last_stamp = last_stamp - STAMP_W'($urandom_range(1, 1000));
      default: last_stamp = STAMP_W'({$urandom(), $urandom()});
    endcase
    it.stamp = last_stamp;
    if ($urandom_range(0, 2) == 0) it.present_mask = MASK_ALL;
    case ($urandom_range(0, 3))
      0: it.temperature = TEMP_W'($urandom_range(0, 8)) - TEMP_W'(4);
      1: it.temperature = $urandom_range(0, 1) ? {1'b0, {(TEMP_W-1){1'b1}}}
                                               : {1'b1, {(TEMP_W-1){1'b0}}};
      default: ;
    endcase
    if ($urandom_range(0, 3) == 0) it.humidity = HUM_W'($urandom_range(4990, 5010));
    if ($urandom_range(0, 3) == 0) it.pressure = PRES_W'($urandom_range(101320, 101330));
    return it;
  endfunction

  task automatic send_item(item_t it);
    int gap;
    gap = sender_calm ? 0 : $urandom_range(0, 11);
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid         <= 1'b1;
    in_op            <= it.op;
    in_stamp         <= it.stamp;
    in_present_mask  <= it.present_mask;
    in_temperature   <= it.temperature;
    in_humidity      <= it.humidity;
    in_pressure      <= it.pressure;
    in_battery       <= it.battery;
    in_spread_factor <= it.spread_factor;
    in_stat_index    <= it.stat_index;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic drain_results();
    @(negedge clk);
    in_valid <= 1'b0;
    wait (pending == 0);
  endtask

  // Result side: a random stall before each transaction, with quiet stretches.
  initial begin
    int hold;
    int taken;
    out_stall = 1'b0;
    taken = 0;
    receiver_calm = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      if (taken % 40 == 0) receiver_calm = ($urandom_range(0, 3) == 0);
      hold = receiver_calm ? 0 : $urandom_range(0, 11);
      if (hold > 0) begin
        @(negedge clk);
        out_stall <= 1'b1;
        repeat (hold - 1) @(negedge clk);
      end
      @(negedge clk);
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
      taken++;
    end
  end

  initial begin
    rst_n            = 1'b0;
    in_valid         = 1'b0;
    in_op            = OP_ACC;
    in_stamp         = '0;
    in_present_mask  = '0;
    in_temperature   = '0;
    in_humidity      = '0;
    in_pressure      = '0;
    in_battery       = '0;
    in_spread_factor = '0;
    in_stat_index    = '0;
    sender_calm      = 1'b0;
    last_stamp       = STAMP_W'(1000);
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;

    // Empty statistics read their reset values.
    send_item(make_read(STAT_TEMP_MIN));
    send_item(make_read(STAT_TEMP_MAX));
    send_item(make_read(STAT_PERIOD_VALID));
    send_item(make_read(STAT_BATT_FLAGS));
    // A record with nothing present still moves the period and the count.
    send_item(make_record(40'd100, MASK_NONE, '0, '0, '0, '0, '0));
    send_item(make_record(40'd200, MASK_ALL, 16'sh8000, '0, '0, '0, '0));
    send_item(make_record(40'd50, MASK_ALL, 16'sh7FFF, '1, '1, '1, 5'd21));
    // Same stamp and same extremes again: nothing may move but the sums and the count.
    send_item(make_record(40'd200, MASK_ALL, 16'sh7FFF, '1, '1, 16'd1234, 5'd22));
    send_item(make_record(40'd300, 5'b10000, '0, '0, '0, '0, '1));
    // Battery at a stamp equal to the earliest one keeps the older reading.
    send_item(make_record(40'd50, 5'b01000, '0, '0, '0, 16'd777, '0));
    send_item(make_record('1, MASK_ALL, 16'sd1, 14'd5000, 17'd101325, 16'd3300, 5'd7));
    send_item(make_read(STAT_TEMP_MIN));
    send_item(make_read(STAT_TEMP_MAX));
    send_item(make_read(STAT_TEMP_MIN_TIME));
    send_item(make_read(STAT_TEMP_MAX_TIME));
    send_item(make_read(STAT_TEMP_SUM));
    send_item(make_read(STAT_BATT_FIRST));
    send_item(make_read(STAT_BATT_LAST_T));
    send_item(make_read(STAT_SF_SEEN));
    send_item(make_read(STAT_PERIOD_START));
    send_item(make_read(STAT_COUNT));
    send_item(make_read(IDX_UNUSED_LO));
    send_item(make_read(IDX_UNUSED_HI));
    drain_results();

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i % 64 == 0) sender_calm = ($urandom_range(0, 3) == 0);
      if (i == RANDOM_ITEMS / 2) drain_results();
      if ($urandom_range(0, 99) < 35)
        send_item(make_read(IDX_W'($urandom_range(0, 31))));
      else
        send_item(random_record());
    end

    drain_results();
    repeat (10) @(posedge clk);
    if (fail_count == 0 && pending == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule
